// ----- hdl/ptfl_pkg.sv -----
// Shared types and constants of the paged translation block.
package ptfl_pkg;

	localparam int FRAME_COUNT_DEF       = 16;
	localparam int PAGES_PER_PROCESS_DEF = 16;
	localparam int PROCESS_SLOTS_DEF     = 8;
	localparam int PAGE_BYTES_DEF        = 256;

	localparam int Q_DEPTH = 2;

	localparam logic [1:0] OP_ACCESS = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [1:0] {
		K_ACCESS,
		K_ALLOC,
		K_FREE,
		K_INVALID
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pid;
		logic [15:0] addr;
		logic [7:0]  count;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_CLEAR,
		S_FREE,
		S_MAP_RD,
		S_MAP_CHK,
		S_SCAN,
		S_VICT_RD,
		S_VICT_UNMAP,
		S_LOAD
	} state_t;

endpackage

// ----- hdl/ptfl_front.sv -----
// Front end: takes command words, classifies them and hands them to the queue.
module ptfl_front #(
	parameter int PAGES_PER_PROCESS = ptfl_pkg::PAGES_PER_PROCESS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    operation,
	input  logic [7:0]    pid,
	input  logic [15:0]   virt_addr,
	input  logic [7:0]    page_count,
	input  logic          q_full,
	output logic          q_push,
	output ptfl_pkg::cmd_t q_wdata
);
	import ptfl_pkg::*;

	logic  vld_s1;
	cmd_t  cmd_s1;
	kind_t kind_c;
	logic  take_c;

	assign busy    = vld_s1;
	assign take_c  = start && !vld_s1;
	assign q_push  = vld_s1 && !q_full;
	assign q_wdata = cmd_s1;

	// Count checks need no state, so they are settled here.
	always_comb begin
		unique case (operation)
			OP_ACCESS: kind_c = K_ACCESS;
			OP_ALLOC: begin
				if (page_count == 8'd0 || 9'(page_count) > 9'(PAGES_PER_PROCESS))
					kind_c = K_INVALID;
				else
					kind_c = K_ALLOC;
			end
			OP_FREE:   kind_c = K_FREE;
			default:   kind_c = K_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_c) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_c) begin
			cmd_s1.kind  <= kind_c;
			cmd_s1.pid   <= pid;
			cmd_s1.addr  <= virt_addr;
			cmd_s1.count <= page_count;
		end
	end

endmodule

// ----- hdl/ptfl_queue.sv -----
// Short command queue between the front end and the execution engine.
module ptfl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptfl_pkg::cmd_t wdata,
	input  logic           pop,
	output ptfl_pkg::cmd_t rdata,
	output logic           full,
	output logic           empty
);
	import ptfl_pkg::*;

	localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t            mem_q [Q_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ----- hdl/ptfl_back.sv -----
// Execution engine: slot table, page map, frame table and replacement search.
module ptfl_back #(
	parameter int FRAME_COUNT       = ptfl_pkg::FRAME_COUNT_DEF,
	parameter int PAGES_PER_PROCESS = ptfl_pkg::PAGES_PER_PROCESS_DEF,
	parameter int PROCESS_SLOTS     = ptfl_pkg::PROCESS_SLOTS_DEF,
	parameter int PAGE_BYTES        = ptfl_pkg::PAGE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mode,
	input  logic           q_empty,
	input  ptfl_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           done,
	output logic [1:0]     status,
	output logic [11:0]    phys_addr,
	output logic           page_fault,
	output logic [31:0]    access_total,
	output logic [31:0]    fault_total
);
	import ptfl_pkg::*;

	localparam int FW        = $clog2(FRAME_COUNT);
	localparam int FCW       = $clog2(FRAME_COUNT + 1);
	localparam int PW        = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
	localparam int CNTW      = $clog2(PAGES_PER_PROCESS + 1);
	localparam int SW        = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
	localparam int MAP_DEPTH = PROCESS_SLOTS * PAGES_PER_PROCESS;
	localparam int MAW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int OFF_W     = $clog2(PAGE_BYTES);

	state_t state_q, state_n;
	cmd_t   cmd_q;

	logic            slot_act_q [PROCESS_SLOTS];
	logic [7:0]      slot_pid_q [PROCESS_SLOTS];
	logic [CNTW-1:0] slot_pg_q  [PROCESS_SLOTS];

	logic [FW:0]     map_mem [MAP_DEPTH];
	logic [FW:0]     map_rd_q;
	logic [7:0]      own_mem [FRAME_COUNT];
	logic [PW-1:0]   fpg_mem [FRAME_COUNT];
	logic [31:0]     ld_mem  [FRAME_COUNT];
	logic [31:0]     us_mem  [FRAME_COUNT];
	logic [7:0]      own_rd_q;
	logic [PW-1:0]   fpg_rd_q;
	logic [31:0]     ld_rd_q;
	logic [31:0]     us_rd_q;
	logic [FRAME_COUNT-1:0] busy_q;

	logic [31:0]     load_st_q, use_st_q, acc_q, flt_q;
	logic [SW-1:0]   tgt_slot_q;
	logic [PW-1:0]   pg_q;
	logic [OFF_W-1:0] off_q;
	logic [CNTW-1:0] clr_q;
	logic [FCW-1:0]  scan_q;
	logic            rd_vld_q;
	logic [FW-1:0]   rd_idx_q;
	logic            free_fnd_q;
	logic [FW-1:0]   free_idx_q, best_idx_q, victim_q;
	logic [31:0]     best_age_q;
	logic            done_q, fault_q;
	logic [1:0]      status_q;
	logic [11:0]     phys_q;

	logic            hit_vld_c, free_vld_c, own_vld_c;
	logic [SW-1:0]   hit_idx_c, free_idx_c, own_idx_c;
	logic [15:0]     page_c;
	logic            pg_ok_c, map_hit_c, scan_end_c, own_pg_ok_c;
	logic [MAW-1:0]  acc_idx_c, map_addr_c;
	logic            map_we_c;
	logic [FW:0]     map_wd_c;
	logic [FW-1:0]   fraddr_c, fwaddr_c;
	logic            us_we_c, ld_we_c;
	logic            fin_c, fin_flt_c;
	logic [1:0]      fin_st_c;
	logic [11:0]     fin_phys_c;
	logic            sc_free_n;
	logic [FW-1:0]   sc_free_idx_n, sc_best_n;
	logic [31:0]     sc_age_n, age_c;

	function automatic logic [MAW-1:0] midx(input logic [SW-1:0] s, input logic [PW-1:0] p);
		return MAW'(32'(s) * PAGES_PER_PROCESS + 32'(p));
	endfunction

	function automatic logic [11:0] phys_f(input logic [FW-1:0] fr, input logic [OFF_W-1:0] off);
		return 12'((32'(fr) << OFF_W) | 32'(off));
	endfunction

	// Parallel compare over the slot table; the lowest matching slot wins.
	always_comb begin
		hit_vld_c  = 1'b0;
		hit_idx_c  = '0;
		free_vld_c = 1'b0;
		free_idx_c = '0;
		own_vld_c  = 1'b0;
		own_idx_c  = '0;
		for (int s = PROCESS_SLOTS - 1; s >= 0; s--) begin
			if (slot_act_q[s] && slot_pid_q[s] == cmd_q.pid) begin
				hit_vld_c = 1'b1;
				hit_idx_c = SW'(s);
			end
			if (!slot_act_q[s]) begin
				free_vld_c = 1'b1;
				free_idx_c = SW'(s);
			end
			if (slot_act_q[s] && slot_pid_q[s] == own_rd_q) begin
				own_vld_c = 1'b1;
				own_idx_c = SW'(s);
			end
		end
	end

	assign page_c      = cmd_q.addr >> OFF_W;
	assign pg_ok_c     = (page_c < 16'(slot_pg_q[hit_idx_c])) &&
	                     (page_c < 16'(PAGES_PER_PROCESS));
	assign own_pg_ok_c = (16'(fpg_rd_q) < 16'(slot_pg_q[own_idx_c])) &&
	                     (16'(fpg_rd_q) < 16'(PAGES_PER_PROCESS));
	assign acc_idx_c   = midx(tgt_slot_q, pg_q);
	assign map_hit_c   = map_rd_q[FW] && ((FCW+1)'(map_rd_q[FW-1:0]) < (FCW+1)'(FRAME_COUNT));
	assign scan_end_c  = (scan_q == FCW'(FRAME_COUNT));

	// Running victim search: first free frame, and oldest frame by stamp distance.
	always_comb begin
		sc_free_n     = free_fnd_q;
		sc_free_idx_n = free_idx_q;
		sc_best_n     = best_idx_q;
		sc_age_n      = best_age_q;
		age_c         = mode ? (use_st_q - us_rd_q) : (load_st_q - ld_rd_q);
		if (rd_vld_q) begin
			if (!busy_q[rd_idx_q] && !free_fnd_q) begin
				sc_free_n     = 1'b1;
				sc_free_idx_n = rd_idx_q;
			end
			if (rd_idx_q == '0 || age_c > best_age_q) begin
				sc_best_n = rd_idx_q;
				sc_age_n  = age_c;
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		q_pop      = 1'b0;
		fin_c      = 1'b0;
		fin_st_c   = ST_OK;
		fin_phys_c = '0;
		fin_flt_c  = 1'b0;
		map_addr_c = acc_idx_c;
		map_we_c   = 1'b0;
		map_wd_c   = '0;
		fraddr_c   = scan_q[FW-1:0];
		fwaddr_c   = victim_q;
		us_we_c    = 1'b0;
		ld_we_c    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_n = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_n = S_IDLE;
				fin_c   = 1'b1;
				unique case (cmd_q.kind)
					K_ALLOC: begin
						if (hit_vld_c) begin
							fin_st_c = ST_INVALID;
						end else if (!free_vld_c) begin
							fin_st_c = ST_FULL;
						end else begin
							fin_c   = 1'b0;
							state_n = S_CLEAR;
						end
					end
					K_FREE: begin
						if (!hit_vld_c) begin
							fin_st_c = ST_NOT_FOUND;
						end else begin
							fin_c   = 1'b0;
							state_n = S_FREE;
						end
					end
					K_ACCESS: begin
						if (!hit_vld_c) begin
							fin_st_c = ST_NOT_FOUND;
						end else if (!pg_ok_c) begin
							fin_st_c = ST_INVALID;
						end else begin
							fin_c   = 1'b0;
							state_n = S_MAP_RD;
						end
					end
					default: fin_st_c = ST_INVALID;
				endcase
			end
			S_CLEAR: begin
				map_addr_c = midx(tgt_slot_q, clr_q[PW-1:0]);
				map_we_c   = 1'b1;
				if ((9'(clr_q) + 9'd1) == 9'(cmd_q.count)) begin
					fin_c   = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_FREE: begin
				if (scan_end_c) begin
					fin_c   = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_MAP_RD: state_n = S_MAP_CHK;
			S_MAP_CHK: begin
				if (map_hit_c) begin
					us_we_c    = 1'b1;
					fwaddr_c   = map_rd_q[FW-1:0];
					fin_c      = 1'b1;
					fin_phys_c = phys_f(map_rd_q[FW-1:0], off_q);
					state_n    = S_IDLE;
				end else begin
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end_c)
					state_n = sc_free_n ? S_LOAD : S_VICT_RD;
			end
			S_VICT_RD: begin
				fraddr_c = victim_q;
				state_n  = S_VICT_UNMAP;
			end
			S_VICT_UNMAP: begin
				if (own_vld_c && own_pg_ok_c) begin
					map_addr_c = midx(own_idx_c, fpg_rd_q);
					map_we_c   = 1'b1;
				end
				state_n = S_LOAD;
			end
			S_LOAD: begin
				map_we_c   = 1'b1;
				map_wd_c   = {1'b1, victim_q};
				us_we_c    = 1'b1;
				ld_we_c    = 1'b1;
				fin_c      = 1'b1;
				fin_flt_c  = 1'b1;
				fin_phys_c = phys_f(victim_q, off_q);
				state_n    = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < PROCESS_SLOTS; s++) begin
				slot_act_q[s] <= 1'b0;
				slot_pid_q[s] <= '0;
				slot_pg_q[s]  <= '0;
			end
			busy_q     <= '0;
			load_st_q  <= '0;
			use_st_q   <= '0;
			acc_q      <= '0;
			flt_q      <= '0;
			clr_q      <= '0;
			scan_q     <= '0;
			rd_vld_q   <= 1'b0;
			free_fnd_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q     <= fin_c;
			rd_vld_q   <= (state_q == S_SCAN || state_q == S_FREE) && !scan_end_c;
			// The free-frame flag starts clear for every frame sweep of a fault.
			free_fnd_q <= (state_q == S_MAP_CHK) ? 1'b0 : sc_free_n;
			unique case (state_q)
				S_DECIDE: begin
					if (cmd_q.kind == K_ALLOC && !hit_vld_c && free_vld_c) begin
						slot_act_q[free_idx_c] <= 1'b1;
						slot_pid_q[free_idx_c] <= cmd_q.pid;
						slot_pg_q[free_idx_c]  <= CNTW'(cmd_q.count);
						clr_q                  <= '0;
					end
					if (cmd_q.kind == K_ACCESS && hit_vld_c && pg_ok_c)
						acc_q <= acc_q + 32'd1;
					if (cmd_q.kind == K_FREE)
						scan_q <= '0;
				end
				S_CLEAR: clr_q <= clr_q + CNTW'(1);
				S_FREE: begin
					if (!scan_end_c)
						scan_q <= scan_q + FCW'(1);
					if (rd_vld_q && busy_q[rd_idx_q] && own_rd_q == cmd_q.pid)
						busy_q[rd_idx_q] <= 1'b0;
					if (scan_end_c) begin
						slot_act_q[tgt_slot_q] <= 1'b0;
						slot_pid_q[tgt_slot_q] <= '0;
						slot_pg_q[tgt_slot_q]  <= '0;
					end
				end
				S_MAP_CHK: begin
					if (map_hit_c) begin
						use_st_q <= use_st_q + 32'd1;
					end else begin
						flt_q  <= flt_q + 32'd1;
						scan_q <= '0;
					end
				end
				S_SCAN: begin
					if (!scan_end_c)
						scan_q <= scan_q + FCW'(1);
				end
				S_LOAD: begin
					busy_q[victim_q] <= 1'b1;
					load_st_q        <= load_st_q + 32'd1;
					use_st_q         <= use_st_q + 32'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_data;
		if (state_q == S_DECIDE) begin
			tgt_slot_q <= (cmd_q.kind == K_ALLOC) ? free_idx_c : hit_idx_c;
			pg_q       <= page_c[PW-1:0];
			off_q      <= cmd_q.addr[OFF_W-1:0];
		end
		rd_idx_q      <= scan_q[FW-1:0];
		free_idx_q    <= sc_free_idx_n;
		best_idx_q    <= sc_best_n;
		best_age_q    <= sc_age_n;
		if (state_q == S_SCAN)
			victim_q <= sc_free_n ? sc_free_idx_n : sc_best_n;
		if (fin_c) begin
			status_q <= fin_st_c;
			phys_q   <= fin_phys_c;
			fault_q  <= fin_flt_c;
		end
	end

	always_ff @(posedge clk) begin
		map_rd_q <= map_mem[map_addr_c];
		if (map_we_c)
			map_mem[map_addr_c] <= map_wd_c;
	end

	always_ff @(posedge clk) begin
		own_rd_q <= own_mem[fraddr_c];
		fpg_rd_q <= fpg_mem[fraddr_c];
		ld_rd_q  <= ld_mem[fraddr_c];
		us_rd_q  <= us_mem[fraddr_c];
		if (us_we_c)
			us_mem[fwaddr_c] <= use_st_q;
		if (ld_we_c) begin
			own_mem[fwaddr_c] <= cmd_q.pid;
			fpg_mem[fwaddr_c] <= pg_q;
			ld_mem[fwaddr_c]  <= load_st_q;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign phys_addr     = phys_q;
	assign page_fault    = fault_q;
	assign access_total  = acc_q;
	assign fault_total   = flt_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_fault_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && fault_q) |-> (status_q == ST_OK))
		else $error("page fault reported on a failed item");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_DECIDE))
		else $error("command taken while the engine was working");

endmodule

// ----- hdl/paged_translation_fifo_lru.sv -----
// Top level of the demand-paged address translator with FIFO or LRU replacement.
//
// Usage: a command word (operation, pid, virt_addr, page_count) is taken at a
// rising edge where start is high and busy is low. Every command produces exactly
// one result word, shown for a single cycle with done high: status, phys_addr,
// page_fault and the running access and fault totals. The receiver cannot stall,
// so it must capture the result in the cycle that done is high.
// The replacement mode register is written through cfg_valid and cfg_data; the
// port is always ready and should only be written while no command is in flight.
// A front end registers and classifies each command and drops it into a two
// word queue; the execution engine pops one command at a time.
// A rejected command ends in the decide state; an access goes on to the map read
// and map check states; an allocate clears one page map entry per page; a free
// sweeps the frame table; a fault sweeps it too and then loads a free frame, or
// reads, unmaps and reloads the victim. The sweep reads one frame table entry per
// cycle. busy stays high while the front end holds a command that the full queue
// cannot take. Reset clears the slot table, frame busy bits, stamps, totals and
// the mode; the page map needs no clearing pass since an allocate writes every
// entry that its process can reach.
module paged_translation_fifo_lru #(
	parameter int FRAME_COUNT       = ptfl_pkg::FRAME_COUNT_DEF,
	parameter int PAGES_PER_PROCESS = ptfl_pkg::PAGES_PER_PROCESS_DEF,
	parameter int PROCESS_SLOTS     = ptfl_pkg::PROCESS_SLOTS_DEF,
	parameter int PAGE_BYTES        = ptfl_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  pid,
	input  logic [15:0] virt_addr,
	input  logic [7:0]  page_count,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] phys_addr,
	output logic        page_fault,
	output logic [31:0] access_total,
	output logic [31:0] fault_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import ptfl_pkg::*;

	logic mode_q;
	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_wdata, q_rdata;

	// The mode register can always take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	ptfl_front #(
		.PAGES_PER_PROCESS(PAGES_PER_PROCESS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.pid(pid),
		.virt_addr(virt_addr),
		.page_count(page_count),
		.q_full(q_full),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	ptfl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	ptfl_back #(
		.FRAME_COUNT(FRAME_COUNT),
		.PAGES_PER_PROCESS(PAGES_PER_PROCESS),
		.PROCESS_SLOTS(PROCESS_SLOTS),
		.PAGE_BYTES(PAGE_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mode(mode_q),
		.q_empty(q_empty),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.done(done),
		.status(status),
		.phys_addr(phys_addr),
		.page_fault(page_fault),
		.access_total(access_total),
		.fault_total(fault_total)
	);

endmodule
